// ----- rtl/lkvc_pkg.sv -----
// Shared types, sizes and controller states of the LRU key/value cache.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_APPLY,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_get;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/lkvc_ctrl.sv -----
// Controller state machine that sequences the scan, update and result of each beat.
module lkvc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lkvc_pkg::dp_status_t status,
  output lkvc_pkg::ctrl_cmd_t  cmd
);

  lkvc_pkg::state_t state_r;
  lkvc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = lkvc_pkg::ST_LAST;
        end
      end
      lkvc_pkg::ST_LAST: begin
        state_nxt = lkvc_pkg::ST_APPLY;
      end
      lkvc_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.is_get) begin
          state_nxt = lkvc_pkg::ST_PUSH;
        end else begin
          state_nxt = lkvc_pkg::ST_IDLE;
        end
      end
      lkvc_pkg::ST_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lkvc_datapath.sv -----
// Datapath of the cache: key and value memories, recency ranks, scan trackers and result register.
module lkvc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
  input  lkvc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lkvc_pkg::out_item_t        out_data,
  input  lkvc_pkg::ctrl_cmd_t        cmd,
  output lkvc_pkg::dp_status_t       status
);

  localparam int IDX_W = lkvc_pkg::IDX_W;
  localparam int AGE_W = lkvc_pkg::AGE_W;
  localparam int CNT_W = lkvc_pkg::CNT_W;
  localparam int ENTRIES = lkvc_pkg::ENTRIES;

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] val_mem [ENTRIES];

  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic [ENTRIES-1:0]         valid_r;
  logic [ENTRIES-1:0]         valid_nxt;
  logic [AGE_W-1:0]           age_r   [ENTRIES];
  logic [AGE_W-1:0]           age_nxt [ENTRIES];
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  logic              op_r;
  logic [31:0]       key_r;
  logic [31:0]       val_r;
  logic [IDX_W-1:0]  idx_r;
  logic [31:0]       key_q_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic              found_r;
  logic [IDX_W-1:0]  pos_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_r;
  logic              vict_found_r;
  logic [IDX_W-1:0]  vict_r;
  logic [AGE_W-1:0]  vict_age_r;
  logic [31:0]       val_q_r;
  logic              hit_q_r;
  logic              out_valid_r;
  lkvc_pkg::out_item_t out_data_r;

  logic [CNT_W-1:0]  eff_cap;
  logic              is_full;
  logic              do_evict;
  logic              do_insert;
  logic              do_touch;
  logic [IDX_W-1:0]  tgt;
  logic [AGE_W-1:0]  tgt_age;
  logic              cmp_v;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign is_full   = (count_r >= eff_cap);
  assign do_evict  = op_r && !found_r && is_full && vict_found_r;
  assign do_insert = op_r && !found_r && !do_evict;
  assign do_touch  = found_r || do_evict;
  assign cmp_v     = valid_r[cmp_idx_r];

  always_comb begin
    if (found_r) begin
      tgt = pos_r;
    end else if (do_evict) begin
      tgt = vict_r;
    end else begin
      tgt = free_r;
    end
  end

  assign tgt_age = age_r[tgt];

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      if (do_touch) begin
        if (IDX_W'(i) == tgt) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (age_r[i] < tgt_age)) begin
          age_nxt[i] = AGE_W'(age_r[i] + 1'b1);
        end
      end else if (do_insert) begin
        if (IDX_W'(i) == tgt) begin
          age_nxt[i] = '0;
        end else if (valid_r[i]) begin
          age_nxt[i] = AGE_W'(age_r[i] + 1'b1);
        end
      end
    end
    if (do_insert) begin
      valid_nxt[tgt] = 1'b1;
      count_nxt      = CNT_W'(count_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lkvc_pkg::CAP_RESET;
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.apply) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          age_r[i] <= age_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      key_q_r <= key_mem[idx_r];
    end
    if (cmd.apply && op_r) begin
      if (!found_r) begin
        key_mem[tgt] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      val_q_r <= val_mem[tgt];
      hit_q_r <= found_r;
      if (op_r) begin
        val_mem[tgt] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r         <= in_data.op;
      key_r        <= in_data.lookup_key;
      val_r        <= in_data.store_value;
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      vict_found_r <= 1'b0;
    end else begin
      if (cmd.scan) begin
        idx_r <= IDX_W'(idx_r + 1'b1);
      end
      if (cmp_vld_r) begin
        if (cmp_v && (key_q_r == key_r) && !found_r) begin
          found_r <= 1'b1;
          pos_r   <= cmp_idx_r;
        end
        if (!cmp_v && !free_found_r) begin
          free_found_r <= 1'b1;
          free_r       <= cmp_idx_r;
        end
        if (cmp_v && (!vict_found_r || (age_r[cmp_idx_r] > vict_age_r))) begin
          vict_found_r <= 1'b1;
          vict_r       <= cmp_idx_r;
          vict_age_r   <= age_r[cmp_idx_r];
        end
      end
    end
    cmp_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.hit        <= hit_q_r;
      out_data_r.read_value <= hit_q_r ? val_q_r : 32'sd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.scan_last = (idx_r == IDX_W'(ENTRIES - 1));
  assign status.is_get    = (op_r == lkvc_pkg::OP_GET);
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_item_t  (op, lookup_key, store_value)
//   out_     output     out_valid / out_stall out_item_t (hit, read_value)
//   cfg_     input      cfg_wr_en             cfg_wr_data (capacity in use)
//
// One beat is taken at a time: each set or get runs the serial key scan over the single
// read port of the key memory, then its update, and a get its result, before the next
// acceptance. A result waits in the output register while the next beat is taken. Reset
// is synchronous and clears all valid marks and the count at once. A get waits in its
// last step while the output register is full and stalled.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lkvc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lkvc_pkg::out_item_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);

  lkvc_pkg::ctrl_cmd_t  cmd;
  lkvc_pkg::dp_status_t status;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
